// ===== rtl/pcm_to_stereo_s16_framer_assert.svh =====
// Assertion macros shared by the framer's top level.
`ifndef PCM_TO_STEREO_S16_FRAMER_ASSERT_SVH
`define PCM_TO_STEREO_S16_FRAMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define P2S_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define P2S_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/p2s_pkg.sv =====
package p2s_pkg;

	// Sample format codes held in the sample_format register.
	localparam logic [1:0] FMT_FLOAT32 = 2'd0;
	localparam logic [1:0] FMT_INT32   = 2'd1;
	localparam logic [1:0] FMT_INT16   = 2'd2;
	localparam logic [1:0] FMT_UCHAR   = 2'd3;

	// Configuration register indexes.
	localparam logic REG_SAMPLE_FORMAT = 1'b0;
	localparam logic REG_CHANNEL_COUNT = 1'b1;

	// Reset values and the channel count that selects mono.
	localparam logic [1:0] FMT_RESET   = FMT_INT16;
	localparam logic [1:0] CHAN_RESET  = 2'd2;
	localparam logic [1:0] CHAN_MONO   = 2'd1;

	// Queue between the front and back ends.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Float scale factor and product width (24-bit mantissa times 15-bit scale).
	localparam logic [14:0] FLOAT_SCALE = 15'd32767;
	localparam int unsigned PROD_W      = 39;

	typedef struct packed {
		logic [31:0] left_raw;
		logic [31:0] right_raw;
	} in_t;

	typedef struct packed {
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic               frame_last;
	} out_t;

	// One channel after classification: either a finished value or a scaled
	// float mantissa that still needs rounding and alignment.
	typedef struct packed {
		logic                is_float;
		logic                neg;
		logic [3:0]          shift;
		logic [PROD_W-1:0]   prod;
		logic signed [15:0]  direct;
	} chan_t;

	typedef struct packed {
		chan_t left;
		chan_t right;
		logic  last;
	} entry_t;

	// Queue status seen by the rest of the block.
	typedef struct packed {
		logic                empty;
		logic                full;
		logic [QUEUE_AW:0]   count;
	} q_stat_t;

endpackage

// ===== rtl/pcm_to_stereo_s16_framer.sv =====
// Converts one interleaved frame of two raw sample words per transfer (float32,
// int32, int16 or unsigned 8-bit, chosen by sample_format) into a signed 16-bit
// stereo pair; with the channel register set to 1 the left sample is sent on both
// channels. frame_last marks every FRAME_PAIRS-th pair. One pair is taken per
// clock while the queue is not full, and one result leaves per clock while pop
// is held and a result is waiting; a pair passes from its input transfer into
// a four-entry queue, written by the classify/multiply front end, and from there
// into the output register, loaded by the rounding back end when it is free or popped.
// Configuration must be written while no pairs are in flight; nothing enforces it.
`include "pcm_to_stereo_s16_framer_assert.svh"

module pcm_to_stereo_s16_framer #(
	parameter int unsigned FRAME_PAIRS = 960
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  logic           wr_index,
	input  logic [1:0]     wr_data,
	input  logic           push,
	output logic           full,
	input  p2s_pkg::in_t   pair_in,
	output logic           empty,
	input  logic           pop,
	output p2s_pkg::out_t  pair_out
);

	logic [1:0]        sample_format_q;
	logic [1:0]        chan_mode_q;
	logic              accept;
	logic              take;
	p2s_pkg::entry_t   front_entry;
	p2s_pkg::entry_t   head_entry;
	p2s_pkg::q_stat_t  q_stat;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_format_q <= p2s_pkg::FMT_RESET;
			chan_mode_q     <= p2s_pkg::CHAN_RESET;
		end else if (wr_en) begin
			case (wr_index)
				p2s_pkg::REG_SAMPLE_FORMAT: sample_format_q <= wr_data;
				p2s_pkg::REG_CHANNEL_COUNT: chan_mode_q     <= wr_data;
				default: ;
			endcase
		end
	end

	assign full   = q_stat.full;
	assign accept = push && !q_stat.full;

	p2s_front #(
		.FRAME_PAIRS(FRAME_PAIRS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.item         (pair_in),
		.sample_format(sample_format_q),
		.mono         (chan_mode_q == p2s_pkg::CHAN_MONO),
		.entry        (front_entry)
	);

	p2s_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (accept),
		.wr_entry(front_entry),
		.rd      (take),
		.rd_entry(head_entry),
		.stat    (q_stat)
	);

	p2s_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.avail (!q_stat.empty),
		.entry (head_entry),
		.take  (take),
		.pop   (pop),
		.empty (empty),
		.result(pair_out)
	);

	// Checks on the queue and the hand-over to the output register.
	`P2S_ASSERT_SAME(a_count_bound, 1'b1, q_stat.count <= (p2s_pkg::QUEUE_AW+1)'(p2s_pkg::QUEUE_DEPTH), "queue count beyond depth")
	`P2S_ASSERT_NEXT(a_accept_lands, accept, !q_stat.empty || !empty, "accepted pair was lost")
	`P2S_ASSERT_NEXT(a_drain_moves, !q_stat.empty && (empty || pop), !empty, "queued pair did not reach the output")

endmodule

// ===== rtl/p2s_front.sv =====
module p2s_front #(
	parameter int unsigned FRAME_PAIRS = 960
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  p2s_pkg::in_t     item,
	input  logic [1:0]       sample_format,
	input  logic             mono,
	output p2s_pkg::entry_t  entry
);

	localparam int unsigned PW = (FRAME_PAIRS > 1) ? $clog2(FRAME_PAIRS) : 1;
	localparam logic [PW-1:0] POS_LAST = PW'(FRAME_PAIRS - 1);

	logic [PW-1:0] pos_q;
	logic          last;

	// Classify one raw word; floats in range get their scaled mantissa here.
	function automatic p2s_pkg::chan_t classify(input logic [31:0] w, input logic [1:0] fmt);
		p2s_pkg::chan_t c;
		logic [7:0]     ex;
		logic [22:0]    fr;
		c.is_float = 1'b0;
		c.neg      = w[31];
		c.shift    = '0;
		c.prod     = '0;
		c.direct   = '0;
		ex         = w[30:23];
		fr         = w[22:0];
		case (fmt)
			p2s_pkg::FMT_FLOAT32: begin
				if (ex == 8'hFF && fr != '0) begin
					c.direct = '0;
				end else if (ex >= 8'd127) begin
					c.direct = w[31] ? -16'sd32767 : 16'sd32767;
				end else if (ex < 8'd111) begin
					c.direct = '0;
				end else begin
					c.is_float = 1'b1;
					c.shift    = 4'(8'd126 - ex);
					c.prod     = {1'b1, fr} * p2s_pkg::FLOAT_SCALE;
				end
			end
			p2s_pkg::FMT_INT32: c.direct = w[31:16];
			p2s_pkg::FMT_INT16: c.direct = w[15:0];
			p2s_pkg::FMT_UCHAR: c.direct = {~w[7], w[6:0], 8'h00};
			default:            c.direct = '0;
		endcase
		return c;
	endfunction

	// Position of the next pair within its frame.
	assign last = (pos_q == POS_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= last ? '0 : pos_q + 1'b1;
		end
	end

	// In mono the left word feeds both channels.
	always_comb begin
		entry.left  = classify(item.left_raw, sample_format);
		entry.right = classify(mono ? item.left_raw : item.right_raw, sample_format);
		entry.last  = last;
	end

endmodule

// ===== rtl/p2s_queue.sv =====
module p2s_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  p2s_pkg::entry_t   wr_entry,
	input  logic              rd,
	output p2s_pkg::entry_t   rd_entry,
	output p2s_pkg::q_stat_t  stat
);

	localparam int unsigned AW = p2s_pkg::QUEUE_AW;
	localparam int unsigned D  = p2s_pkg::QUEUE_DEPTH;

	p2s_pkg::entry_t  slots_q [D];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [AW:0]      count_q;
	logic             do_wr;
	logic             do_rd;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == (AW+1)'(D));
	assign stat.count = count_q;
	assign do_wr      = wr && !stat.full;
	assign do_rd      = rd && !stat.empty;
	assign rd_entry   = slots_q[rptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/p2s_back.sv =====
module p2s_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             avail,
	input  p2s_pkg::entry_t  entry,
	output logic             take,
	input  logic             pop,
	output logic             empty,
	output p2s_pkg::out_t    result
);

	localparam int unsigned PW = p2s_pkg::PROD_W;

	p2s_pkg::out_t out_q;
	logic          valid_q;

	// Round the product to 24 significant bits (nearest, ties to even), then
	// align it to the integer point and apply the sign. Other formats pass direct.
	function automatic logic signed [15:0] finish(input p2s_pkg::chan_t c);
		logic [23:0] keep;
		logic        up;
		logic [4:0]  amt;
		logic [24:0] rk;
		logic [24:0] mag;
		if (c.prod[PW-1]) begin
			keep = c.prod[38:15];
			up   = c.prod[14] && ((|c.prod[13:0]) || c.prod[15]);
			amt  = 5'd9 + 5'(c.shift);
		end else begin
			keep = c.prod[37:14];
			up   = c.prod[13] && ((|c.prod[12:0]) || c.prod[14]);
			amt  = 5'd10 + 5'(c.shift);
		end
		rk  = {1'b0, keep} + 25'(up);
		mag = rk >> amt;
		if (!c.is_float) begin
			return c.direct;
		end
		return c.neg ? -$signed(mag[15:0]) : $signed(mag[15:0]);
	endfunction

	// The output register takes a new pair when it is free or being drained.
	assign take   = avail && (!valid_q || pop);
	assign empty  = !valid_q;
	assign result = out_q;

	always_ff @(posedge clk) begin
		if (take) begin
			out_q.left_sample  <= finish(entry.left);
			out_q.right_sample <= finish(entry.right);
			out_q.frame_last   <= entry.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// ===== tb/sv/pcm_to_stereo_s16_framer_tb.sv =====
module pcm_to_stereo_s16_framer_tb;
	import p2s_pkg::*;

	localparam int unsigned FRAME_LEN     = 960;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned HOLDOFF_LEN   = 250;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        wr_en    = 1'b0;
	logic        wr_index = REG_SAMPLE_FORMAT;
	logic [1:0]  wr_data  = FMT_RESET;
	logic        push     = 1'b0;
	logic        full;
	in_t         pair_in  = '0;
	logic        empty;
	logic        pop      = 1'b0;
	out_t        pair_out;

	// Local copy of the configuration and the frame position.
	logic [1:0]  fmt_cfg;
	logic [1:0]  chan_cfg;
	int unsigned pairs_in_frame;

	out_t        expected_pairs[$];

	int          send_idle_pct     = 0;
	int          recv_idle_pct     = 0;
	bit          holdoff_request   = 1'b0;
	int          holdoff_left      = 0;
	int unsigned cycle_count       = 0;
	int unsigned mismatch_count    = 0;
	int unsigned pairs_sent        = 0;
	int unsigned pairs_checked     = 0;
	int unsigned frame_ends_seen   = 0;
	int unsigned input_stall_count = 0;
	int unsigned config_writes     = 0;

	pcm_to_stereo_s16_framer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.push     (push),
		.full     (full),
		.pair_in  (pair_in),
		.empty    (empty),
		.pop      (pop),
		.pair_out (pair_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("pcm_to_stereo_s16_framer verification failed");
			$finish;
		end
	end

	// Float word to a level: clamp to one, scale by 32767 with single-precision
	// rounding of the product, then truncate toward zero. NaN gives zero.
	function automatic int float_level(logic [31:0] w);
		logic [7:0]        expo;
		logic [22:0]       frac;
		longint unsigned   prod;
		longint unsigned   keep;
		longint unsigned   rem;
		longint unsigned   half;
		int                width;
		int                drop;
		int                b;
		int                mag;
		expo = w[30:23];
		frac = w[22:0];
		if (expo == 8'hFF && frac != '0)
			return 0;
		if (expo >= 8'd127) begin
			mag = 32767;
		end else if (expo < 8'd111) begin
			mag = 0;
		end else begin
			prod = longint'({1'b1, frac}) * 64'd32767;
			width = 0;
			for (b = 0; b < 64; b++)
				if (prod[b])
					width = b + 1;
			// Keep 24 significant bits, ties to even.
			if (width > 24) begin
				drop = width - 24;
				keep = prod >> drop;
				rem  = prod & ((64'd1 << drop) - 1);
				half = 64'd1 << (drop - 1);
				if (rem > half || (rem == half && keep[0]))
					keep++;
				prod = keep << drop;
			end
			mag = int'(prod >> (150 - int'(expo)));
		end
		return w[31] ? -mag : mag;
	endfunction

	// One raw word to a saturated signed 16-bit sample for the given format.
	function automatic logic signed [15:0] sample_from_raw(logic [1:0] fmt, logic [31:0] w);
		int level;
		case (fmt)
			FMT_FLOAT32: level = float_level(w);
			FMT_INT32:   level = int'($signed(w[31:16]));
			FMT_INT16:   level = int'($signed(w[15:0]));
			default:     level = (int'(w[7:0]) - 128) * 256;
		endcase
		if (level > 32767)
			level = 32767;
		else if (level < -32768)
			level = -32768;
		return 16'(level);
	endfunction

	// Expected output pair for one accepted input; advances the frame position.
	function automatic out_t convert_pair(in_t p);
		out_t r;
		r.left_sample  = sample_from_raw(fmt_cfg, p.left_raw);
		r.right_sample = (chan_cfg == CHAN_MONO) ? r.left_sample
			: sample_from_raw(fmt_cfg, p.right_raw);
		pairs_in_frame++;
		r.frame_last = 1'b0;
		if (pairs_in_frame >= FRAME_LEN) begin
			r.frame_last   = 1'b1;
			pairs_in_frame = 0;
		end
		return r;
	endfunction

	// Float words biased toward the scaled range, with specials mixed in.
	function automatic logic [31:0] float_raw();
		logic [31:0] w;
		w = $urandom();
		case ($urandom_range(9))
			0:       w[30:23] = 8'hFF;
			1:       w[30:23] = 8'h00;
			2:       ;
			default: w[30:23] = 8'($urandom_range(128, 108));
		endcase
		return w;
	endfunction

	function automatic in_t random_pair();
		in_t p;
		if (fmt_cfg == FMT_FLOAT32) begin
			p.left_raw  = float_raw();
			p.right_raw = float_raw();
		end else begin
			p.left_raw  = $urandom();
			p.right_raw = $urandom();
		end
		return p;
	endfunction

	// Offer one pair and wait for its input transfer. push stays high on return.
	task automatic offer_pair(in_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		pair_in <= p;
		@(posedge clk);
		while (full) begin
			input_stall_count++;
			@(posedge clk);
		end
		expected_pairs.insert(expected_pairs.size(), convert_pair(p));
		pairs_sent++;
	endtask

	// Let every expected pair drain, then let the pipeline settle.
	task automatic wait_idle();
		push <= 1'b0;
		while (expected_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [1:0] fmt, logic [1:0] chan);
		wait_idle();
		wr_en    <= 1'b1;
		wr_index <= REG_SAMPLE_FORMAT;
		wr_data  <= fmt;
		@(posedge clk);
		wr_index <= REG_CHANNEL_COUNT;
		wr_data  <= chan;
		@(posedge clk);
		wr_en    <= 1'b0;
		fmt_cfg  = fmt;
		chan_cfg = chan;
		config_writes += 2;
	endtask

	task automatic compare_pair(out_t got);
		out_t want;
		if (expected_pairs.size() == 0) begin
			$display("%0t: unexpected result: expected none, actual %h", $time, got);
			mismatch_count++;
			return;
		end
		want = expected_pairs.pop_front();
		if (got.left_sample !== want.left_sample) begin
			$display("%0t: left_sample expected %0d, actual %0d",
				$time, want.left_sample, got.left_sample);
			mismatch_count++;
		end
		if (got.right_sample !== want.right_sample) begin
			$display("%0t: right_sample expected %0d, actual %0d",
				$time, want.right_sample, got.right_sample);
			mismatch_count++;
		end
		if (got.frame_last !== want.frame_last) begin
			$display("%0t: frame_last expected %0b, actual %0b",
				$time, want.frame_last, got.frame_last);
			mismatch_count++;
		end
		if (got.frame_last === 1'b1)
			frame_ends_seen++;
		pairs_checked++;
	endtask

	// Output side: check each result transfer, then decide whether to pop.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty)
				compare_pair(pair_out);
			if (holdoff_request) begin
				holdoff_request = 1'b0;
				holdoff_left    = HOLDOFF_LEN;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Out of reset the block converts int16 stereo; high bits must be ignored.
	task automatic test_reset_defaults();
		offer_pair('{left_raw: 32'hDEAD_7FFF, right_raw: 32'h0001_8000});
		offer_pair('{left_raw: 32'hFFFF_0000, right_raw: 32'h1234_FFFF});
	endtask

	task automatic test_int32_extremes();
		set_config(FMT_INT32, CHAN_RESET);
		offer_pair('{left_raw: 32'h7FFF_FFFF, right_raw: 32'h8000_0000});
		offer_pair('{left_raw: 32'h0000_FFFF, right_raw: 32'hFFFF_0000});
	endtask

	task automatic test_uchar_extremes();
		set_config(FMT_UCHAR, CHAN_RESET);
		offer_pair('{left_raw: 32'h0000_00FF, right_raw: 32'hFFFF_FF00});
		offer_pair('{left_raw: 32'hABCD_EF80, right_raw: 32'h0000_007F});
	endtask

	// Ones, infinities, NaNs of both signs, zeros, a value too small to reach one
	// step, the smallest scaled exponent and the next, values inside one, pi and one sixth.
	task automatic test_float_special_cases();
		set_config(FMT_FLOAT32, CHAN_RESET);
		offer_pair('{left_raw: 32'h3F80_0000, right_raw: 32'hBF80_0000});
		offer_pair('{left_raw: 32'h7F80_0000, right_raw: 32'hFF80_0000});
		offer_pair('{left_raw: 32'h7FC0_0000, right_raw: 32'hFFFF_FFFF});
		offer_pair('{left_raw: 32'h0000_0000, right_raw: 32'h8000_0000});
		offer_pair('{left_raw: 32'h0000_0001, right_raw: 32'h3780_0000});
		offer_pair('{left_raw: 32'h3800_0000, right_raw: 32'hB800_0000});
		offer_pair('{left_raw: 32'h3F00_0000, right_raw: 32'hBF7F_FFFF});
		offer_pair('{left_raw: 32'h4049_0FDB, right_raw: 32'h3E2A_AAAB});
	endtask

	// Only a count of one selects mono; zero and three behave as stereo.
	task automatic test_channel_modes();
		set_config(FMT_INT16, CHAN_MONO);
		offer_pair('{left_raw: 32'h0000_8000, right_raw: 32'h0000_7FFF});
		offer_pair('{left_raw: 32'h0000_1234, right_raw: 32'h0000_5678});
		set_config(FMT_UCHAR, 2'd0);
		offer_pair('{left_raw: 32'h0000_0000, right_raw: 32'h0000_00FF});
		set_config(FMT_FLOAT32, 2'd3);
		offer_pair('{left_raw: 32'h3F40_0000, right_raw: 32'hC0A0_0000});
	endtask

	// The output side stops popping for a long stretch while pairs keep coming.
	task automatic test_backpressure();
		int i;
		set_config(FMT_INT32, CHAN_RESET);
		send_idle_pct   = 0;
		recv_idle_pct   = 0;
		holdoff_request = 1'b1;
		for (i = 0; i < 40; i++)
			offer_pair(random_pair());
	endtask

	// Random pairs under one idling pattern, moving to a new setting now and then.
	task automatic test_random_traffic(int count, int send_pct, int recv_pct);
		int i;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (i = 0; i < count; i++) begin
			if (i % 80 == 0)
				set_config(2'($urandom_range(3)), 2'($urandom_range(3)));
			offer_pair(random_pair());
		end
	endtask

	initial begin
		fmt_cfg        = FMT_RESET;
		chan_cfg       = CHAN_RESET;
		pairs_in_frame = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_int32_extremes();
		test_uchar_extremes();
		test_float_special_cases();
		test_channel_modes();
		test_backpressure();
		test_random_traffic(480, 38, 79);
		test_random_traffic(480, 79, 38);
		test_random_traffic(480, 0, 0);

		wait_idle();
		$display("Checked %0d of %0d pairs over %0d frame ends and %0d register writes.",
			pairs_checked, pairs_sent, frame_ends_seen, config_writes);
		$display("All four formats, mono and stereo; input stalled for %0d cycles.",
			input_stall_count);
		if (mismatch_count == 0) begin
			$display("pcm_to_stereo_s16_framer verification clean");
		end else begin
			$display("pcm_to_stereo_s16_framer verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/p2s_pkg.sv
rtl/p2s_front.sv
rtl/p2s_queue.sv
rtl/p2s_back.sv
rtl/pcm_to_stereo_s16_framer.sv
tb/sv/pcm_to_stereo_s16_framer_tb.sv
